@@ rtl/core/cswq_pkg.sv @@
// Shared types and constants for the counting semaphore wait queue unit.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
package cswq_pkg;

	// Fixed field widths of the request and response
	localparam int KIND_W     = 2;
	localparam int SEM_ID_W   = 5;
	localparam int INIT_W     = 8;
	localparam int PID_W      = 5;
	localparam int STATUS_W   = 2;

	// Parameter defaults
	localparam int NUM_SEMS_DEF   = 32;
	localparam int NUM_PROCS_DEF  = 32;
	localparam int COUNT_BITS_DEF = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_CREATE = 2'd0,
		KIND_LOCK   = 2'd1,
		KIND_UNLOCK = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BLOCKED = 2'd1,
		ST_NOFREE  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic wake;
		logic publish;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_wake;
	} dp_stat_t;

endpackage

@@ rtl/core/cswq_req_if.sv @@
// Request channel of the semaphore unit: valid/ready plus request payload.
// Depends on cswq_pkg.
interface cswq_req_if;
	import cswq_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SEM_ID_W-1:0] sem_id;
	logic [INIT_W-1:0]   initial_count;
	logic [PID_W-1:0]    caller_pid;

	modport source (output valid, kind, sem_id, initial_count, caller_pid, input ready);
	modport sink (input valid, kind, sem_id, initial_count, caller_pid, output ready);
endinterface

@@ rtl/core/cswq_rsp_if.sv @@
// Response channel of the semaphore unit: valid/ready plus result payload.
// Depends on cswq_pkg.
interface cswq_rsp_if;
	import cswq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SEM_ID_W-1:0] new_sem_id;
	logic                woken_valid;
	logic [PID_W-1:0]    woken_pid;

	modport source (output valid, status, new_sem_id, woken_valid, woken_pid, input ready);
	modport sink (input valid, status, new_sem_id, woken_valid, woken_pid, output ready);
endinterface

@@ rtl/core/cswq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cswq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/core/cswq_ctrl.sv @@
// Sequencing controller of the semaphore unit: accept, execute, wake, publish.
// Depends on cswq_pkg.
module cswq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output cswq_pkg::ctrl_cmd_t cmd,
	input  cswq_pkg::dp_stat_t  stat
);
	import cswq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_WAKE = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign req_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_wake ? S_WAKE : S_DONE;
			end
			S_WAKE: begin
				cmd.wake = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/core/cswq_dp.sv @@
// Datapath of the semaphore unit: semaphore table, wait queues, id allocator,
// result and output registers. Depends on cswq_pkg and cswq_ram.
module cswq_dp #(
	parameter int NUM_SEMS   = cswq_pkg::NUM_SEMS_DEF,
	parameter int NUM_PROCS  = cswq_pkg::NUM_PROCS_DEF,
	parameter int COUNT_BITS = cswq_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cswq_pkg::KIND_W-1:0]   req_kind,
	input  logic [cswq_pkg::SEM_ID_W-1:0] req_sem_id,
	input  logic [cswq_pkg::INIT_W-1:0]   req_initial_count,
	input  logic [cswq_pkg::PID_W-1:0]    req_caller_pid,
	input  cswq_pkg::ctrl_cmd_t           cmd,
	output cswq_pkg::dp_stat_t            stat,
	output logic [cswq_pkg::STATUS_W-1:0] out_status,
	output logic [cswq_pkg::SEM_ID_W-1:0] out_new_sem_id,
	output logic                          out_woken_valid,
	output logic [cswq_pkg::PID_W-1:0]    out_woken_pid
);
	import cswq_pkg::*;

	localparam int SAW = $clog2(NUM_SEMS);
	localparam int PW  = $clog2(NUM_PROCS);
	localparam int FW  = $clog2(NUM_PROCS + 1);
	localparam int CW  = COUNT_BITS;
	localparam int EW  = CW + PW + FW;
	localparam int AFW = $clog2(NUM_SEMS + 1);
	localparam int WAW = $clog2(NUM_SEMS * NUM_PROCS);
	localparam int WW  = (CW > INIT_W) ? CW : INIT_W;
	localparam logic [CW-1:0] CNT_MAX = '1;

	// request registers
	logic [KIND_W-1:0]   kind_q;
	logic [SEM_ID_W-1:0] sid_q;
	logic [INIT_W-1:0]   init_q;
	logic [PID_W-1:0]    pid_q;
	logic                vld_rd_q;

	// allocator and table valid bits
	logic [AFW-1:0]      alloc_q;
	logic [NUM_SEMS-1:0] sem_vld_q;

	// result and output registers
	logic [STATUS_W-1:0] res_status_q;
	logic [SEM_ID_W-1:0] res_new_id_q;
	logic                res_wv_q;
	logic [PID_W-1:0]    res_wpid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SEM_ID_W-1:0] out_new_id_q;
	logic                out_wv_q;
	logic [PID_W-1:0]    out_wpid_q;

	logic           sid_in_ok;
	logic [SAW-1:0] rd_idx;
	logic           sid_ok;
	logic [SAW-1:0] sid_idx;
	logic [EW-1:0]  sem_rdata;
	logic [EW-1:0]  ent;
	logic [CW-1:0]  cnt;
	logic [PW-1:0]  head;
	logic [FW-1:0]  fill;
	logic [PW:0]    tail_sum;
	logic [PW-1:0]  tail;
	logic [PW-1:0]  head_nxt;
	logic [WW-1:0]  init_w;
	logic [CW-1:0]  init_sat;

	logic           sem_we;
	logic [SAW-1:0] sem_waddr;
	logic [EW-1:0]  sem_wdata;
	logic           q_we;
	logic           q_re;
	logic [PW-1:0]  slot;
	logic [WAW-1:0] q_addr;
	logic [PW-1:0]  q_rdata;
	logic           alloc_inc;
	status_t        status;
	logic [SEM_ID_W-1:0] new_id;

	assign sid_in_ok = (int'(req_sem_id) < NUM_SEMS);
	assign rd_idx    = sid_in_ok ? SAW'(req_sem_id) : '0;
	assign sid_ok    = (int'(sid_q) < NUM_SEMS);
	assign sid_idx   = sid_ok ? SAW'(sid_q) : '0;

	// an entry never created reads as all zero
	assign ent  = vld_rd_q ? sem_rdata : '0;
	assign cnt  = ent[EW-1 -: CW];
	assign head = ent[FW +: PW];
	assign fill = ent[FW-1:0];

	assign tail_sum = (PW + 1)'(head) + (PW + 1)'(fill);
	assign tail     = (int'(tail_sum) >= NUM_PROCS) ? PW'(tail_sum - (PW + 1)'(NUM_PROCS))
	                                                : PW'(tail_sum);
	assign head_nxt = (head == PW'(NUM_PROCS - 1)) ? '0 : PW'(head + 1'b1);

	assign init_w   = WW'(init_q);
	assign init_sat = (init_w > WW'(CNT_MAX)) ? CNT_MAX : CW'(init_w);

	assign q_addr = WAW'(sid_idx) * WAW'(NUM_PROCS) + WAW'(slot);

	always_comb begin
		sem_we    = 1'b0;
		sem_waddr = sid_idx;
		sem_wdata = ent;
		q_we      = 1'b0;
		q_re      = 1'b0;
		slot      = head;
		alloc_inc = 1'b0;
		status    = ST_OK;
		new_id    = '0;
		case (kind_q)
			KIND_CREATE: begin
				if (alloc_q == AFW'(NUM_SEMS)) begin
					status = ST_NOFREE;
				end else begin
					sem_we    = 1'b1;
					sem_waddr = SAW'(alloc_q);
					sem_wdata = {init_sat, PW'(0), FW'(0)};
					alloc_inc = 1'b1;
					new_id    = SEM_ID_W'(alloc_q);
				end
			end
			KIND_LOCK: begin
				slot = tail;
				if (!sid_ok) begin
					status = ST_NOFREE;
				end else if (cnt != '0) begin
					sem_we    = 1'b1;
					sem_wdata = {CW'(cnt - 1'b1), head, fill};
				end else if (int'(pid_q) >= NUM_PROCS) begin
					status = ST_NOFREE;
				end else if (fill == FW'(NUM_PROCS)) begin
					status = ST_FULL;
				end else begin
					q_we      = 1'b1;
					sem_we    = 1'b1;
					sem_wdata = {cnt, head, FW'(fill + 1'b1)};
					status    = ST_BLOCKED;
				end
			end
			KIND_UNLOCK: begin
				if (!sid_ok) begin
					status = ST_NOFREE;
				end else if (fill == '0) begin
					if (cnt != CNT_MAX) begin
						sem_we    = 1'b1;
						sem_wdata = {CW'(cnt + 1'b1), head, fill};
					end
				end else begin
					// pop the oldest waiter, its id arrives next cycle
					q_re      = 1'b1;
					sem_we    = 1'b1;
					sem_wdata = {cnt, head_nxt, FW'(fill - 1'b1)};
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign stat.need_wake = q_re;

	cswq_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_SEMS)
	) u_sem_ram (
		.clk  (clk),
		.we   (cmd.exec && sem_we),
		.waddr(sem_waddr),
		.wdata(sem_wdata),
		.re   (cmd.capture),
		.raddr(rd_idx),
		.rdata(sem_rdata)
	);

	cswq_ram #(
		.WIDTH(PW),
		.DEPTH(NUM_SEMS * NUM_PROCS)
	) u_wait_ram (
		.clk  (clk),
		.we   (cmd.exec && q_we),
		.waddr(q_addr),
		.wdata(PW'(pid_q)),
		.re   (cmd.exec && q_re),
		.raddr(q_addr),
		.rdata(q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q   <= '0;
			sem_vld_q <= '0;
		end else if (cmd.exec) begin
			if (alloc_inc) begin
				alloc_q <= AFW'(alloc_q + 1'b1);
			end
			if (sem_we) begin
				sem_vld_q[sem_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= req_kind;
			sid_q    <= req_sem_id;
			init_q   <= req_initial_count;
			pid_q    <= req_caller_pid;
			vld_rd_q <= sem_vld_q[rd_idx];
		end
		if (cmd.exec) begin
			res_status_q <= status;
			res_new_id_q <= new_id;
			res_wv_q     <= 1'b0;
			res_wpid_q   <= '0;
		end
		if (cmd.wake) begin
			res_wv_q   <= 1'b1;
			res_wpid_q <= PID_W'(q_rdata);
		end
		if (cmd.publish) begin
			out_status_q <= res_status_q;
			out_new_id_q <= res_new_id_q;
			out_wv_q     <= res_wv_q;
			out_wpid_q   <= res_wpid_q;
		end
	end

	assign out_status      = out_status_q;
	assign out_new_sem_id  = out_new_id_q;
	assign out_woken_valid = out_wv_q;
	assign out_woken_pid   = out_wpid_q;
endmodule

@@ rtl/core/counting_semaphore_wait_queue_unit.sv @@
// Counting semaphore pool with per-semaphore FIFO wait queues.
// A request is captured, then executed; an unlock that wakes a waiter adds a
// wake step to read the wait-queue RAM; then the result is registered out.
// One request in flight at a time; a response not taken stalls the next request
// in the done state until the output register is free.
// Reset: asynchronous, clears control state, allocator and table valid bits.
module counting_semaphore_wait_queue_unit #(
	parameter int NUM_SEMS   = cswq_pkg::NUM_SEMS_DEF,
	parameter int NUM_PROCS  = cswq_pkg::NUM_PROCS_DEF,
	parameter int COUNT_BITS = cswq_pkg::COUNT_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cswq_req_if.sink    req,
	cswq_rsp_if.source  rsp
);
	import cswq_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	cswq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	cswq_dp #(
		.NUM_SEMS  (NUM_SEMS),
		.NUM_PROCS (NUM_PROCS),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_kind         (req.kind),
		.req_sem_id       (req.sem_id),
		.req_initial_count(req.initial_count),
		.req_caller_pid   (req.caller_pid),
		.cmd              (cmd),
		.stat             (stat),
		.out_status       (rsp.status),
		.out_new_sem_id   (rsp.new_sem_id),
		.out_woken_valid  (rsp.woken_valid),
		.out_woken_pid    (rsp.woken_pid)
	);
endmodule
